>>> rtl/core/lkm_pkg.sv
// ----------------------------------------------------------------------------
// lkm_pkg
// Shared types, codes and timer helpers for the link keepalive manager.
// ----------------------------------------------------------------------------
package lkm_pkg;

    // timer counter width and derived limits
    localparam int TIMER_BITS = 18;
    localparam int TMR_SUM_W  = TIMER_BITS + 1;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] CNT_ONE = TIMER_BITS'(1);

    // field widths
    localparam int KIND_W    = 4;
    localparam int MS_W      = 16;
    localparam int TAG_W     = 32;
    localparam int POLL_W    = 16;
    localparam int TIMEOUT_W = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;

    // packet tags
    localparam logic [TAG_W-1:0] TAG_POLL = 32'h5953_4650;
    localparam logic [TAG_W-1:0] TAG_DATA = 32'h5953_4644;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_OPEN   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_LINK   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_UNLINK = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_TICK   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RX     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_TX     = 4'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_VALID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TMO    = 2'd3;

    // configuration reset values
    localparam logic [POLL_W-1:0]    POLL_RST = 16'd5000;
    localparam logic [TIMEOUT_W-1:0] TMO_RST  = 18'd60000;

    typedef enum logic [1:0] {
        PH_NOTOPEN   = 2'd0,
        PH_NOTLINKED = 2'd1,
        PH_LINKING   = 2'd2,
        PH_LINKED    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_POLL    = 3'd1,
        ACT_UNLINK  = 3'd2,
        ACT_OPTIONS = 3'd3,
        ACT_INFO    = 3'd4,
        ACT_FWD_TX  = 3'd5,
        ACT_DLV_RX  = 3'd6
    } t_action;

    typedef struct packed {
        t_phase                phase;
        logic                  send_run;
        logic [TIMER_BITS-1:0] send_cnt;
        logic                  recv_run;
        logic [TIMER_BITS-1:0] recv_cnt;
    } t_link_state;

    typedef struct packed {
        logic                 static_mode;
        logic                 peer_valid;
        logic [POLL_W-1:0]    poll_period;
        logic [TIMEOUT_W-1:0] link_tmo;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MS_W-1:0]   elapsed_ms;
        logic              open_ok;
        logic              from_peer;
        logic [TAG_W-1:0]  tag;
    } t_item;

    typedef struct packed {
        t_action act0;
        t_action act1;
        logic    two;
        logic    lost;
    } t_step_res;

    // saturating advance of a running timer with a non-zero period
    function automatic logic [TIMER_BITS-1:0] tmr_adv(
        input logic                  run,
        input logic [TIMER_BITS-1:0] cnt,
        input logic [TIMER_BITS-1:0] period,
        input logic [MS_W-1:0]       ms
    );
        logic [TMR_SUM_W-1:0] sum;
        sum = {1'b0, cnt} + TMR_SUM_W'(ms);
        if (run && (period != '0)) begin
            return sum[TIMER_BITS] ? CNT_MAX : sum[TIMER_BITS-1:0];
        end
        return cnt;
    endfunction

    // a running timer has expired once its count reaches the period
    function automatic logic tmr_exp(
        input logic                  run,
        input logic [TIMER_BITS-1:0] cnt,
        input logic [TIMER_BITS-1:0] period
    );
        return run && (period != '0) && (cnt >= period);
    endfunction

endpackage

>>> rtl/core/lkm_step.sv
// ----------------------------------------------------------------------------
// lkm_step
// Next link state and result actions for one event, pure combinational.
// ----------------------------------------------------------------------------
module lkm_step (
    input  lkm_pkg::t_link_state i_state,
    input  lkm_pkg::t_cfg        i_cfg,
    input  lkm_pkg::t_item       i_item,
    output lkm_pkg::t_link_state o_state,
    output lkm_pkg::t_step_res   o_res
);

    logic [lkm_pkg::TIMER_BITS-1:0] poll_per;
    logic [lkm_pkg::TIMER_BITS-1:0] tmo_per;
    logic [lkm_pkg::TIMER_BITS-1:0] recv_adv;
    logic [lkm_pkg::TIMER_BITS-1:0] send_adv;
    logic                           recv_exp;
    logic                           send_exp;
    lkm_pkg::t_link_state           tick_st;

    assign poll_per = lkm_pkg::TIMER_BITS'(i_cfg.poll_period);
    assign tmo_per  = lkm_pkg::TIMER_BITS'(i_cfg.link_tmo);

    // tick path: receive timer first, then send timer on the updated state
    always_comb begin
        tick_st  = i_state;
        recv_adv = lkm_pkg::tmr_adv(i_state.recv_run, i_state.recv_cnt, tmo_per,
                                    i_item.elapsed_ms);
        recv_exp = lkm_pkg::tmr_exp(i_state.recv_run, recv_adv, tmo_per);
        tick_st.recv_cnt = recv_adv;
        if (recv_exp) begin
            if (i_cfg.static_mode) begin
                tick_st.phase = lkm_pkg::PH_LINKING;
            end else begin
                tick_st.phase    = lkm_pkg::PH_NOTLINKED;
                tick_st.send_run = 1'b0;
                tick_st.send_cnt = '0;
            end
            tick_st.recv_run = 1'b0;
            tick_st.recv_cnt = '0;
        end
        send_adv = lkm_pkg::tmr_adv(tick_st.send_run, tick_st.send_cnt, poll_per,
                                    i_item.elapsed_ms);
        send_exp = lkm_pkg::tmr_exp(tick_st.send_run, send_adv, poll_per);
        tick_st.send_cnt = send_adv;
        if (send_exp) begin
            tick_st.send_run = 1'b1;
            tick_st.send_cnt = lkm_pkg::CNT_ONE;
        end
    end

    // event decode
    always_comb begin
        o_state = i_state;
        o_res   = '{act0: lkm_pkg::ACT_NONE, act1: lkm_pkg::ACT_NONE,
                    two: 1'b0, lost: 1'b0};
        case (i_item.kind)
            lkm_pkg::KIND_OPEN: begin
                o_state.phase = (i_cfg.peer_valid && i_item.open_ok) ?
                                lkm_pkg::PH_NOTLINKED : lkm_pkg::PH_NOTOPEN;
            end
            lkm_pkg::KIND_LINK: begin
                if (i_state.phase == lkm_pkg::PH_NOTLINKED) begin
                    o_state.phase    = lkm_pkg::PH_LINKING;
                    o_state.send_run = 1'b1;
                    o_state.send_cnt = lkm_pkg::CNT_ONE;
                    o_state.recv_run = 1'b1;
                    o_state.recv_cnt = lkm_pkg::CNT_ONE;
                    o_res.act0       = lkm_pkg::ACT_POLL;
                end
            end
            lkm_pkg::KIND_UNLINK: begin
                if (i_state.phase == lkm_pkg::PH_LINKED) begin
                    o_state.phase    = lkm_pkg::PH_NOTLINKED;
                    o_state.send_run = 1'b0;
                    o_state.send_cnt = '0;
                    o_state.recv_run = 1'b0;
                    o_state.recv_cnt = '0;
                    o_res.act0       = lkm_pkg::ACT_UNLINK;
                end
            end
            lkm_pkg::KIND_CLOSE: begin
                o_state.phase = lkm_pkg::PH_NOTOPEN;
            end
            lkm_pkg::KIND_TICK: begin
                if (i_state.phase != lkm_pkg::PH_NOTOPEN) begin
                    o_state    = tick_st;
                    o_res.lost = recv_exp;
                    if (send_exp && ((tick_st.phase == lkm_pkg::PH_LINKING) ||
                                     (tick_st.phase == lkm_pkg::PH_LINKED))) begin
                        o_res.act0 = lkm_pkg::ACT_POLL;
                    end
                end
            end
            lkm_pkg::KIND_RX: begin
                if ((i_state.phase != lkm_pkg::PH_NOTOPEN) && i_cfg.peer_valid &&
                    i_item.from_peer) begin
                    if (i_item.tag == lkm_pkg::TAG_POLL) begin
                        o_state.recv_run = 1'b1;
                        o_state.recv_cnt = lkm_pkg::CNT_ONE;
                        if (i_state.phase == lkm_pkg::PH_LINKING) begin
                            o_state.phase = lkm_pkg::PH_LINKED;
                            o_res.act0    = lkm_pkg::ACT_OPTIONS;
                            o_res.act1    = lkm_pkg::ACT_INFO;
                            o_res.two     = 1'b1;
                        end
                    end else if (i_item.tag == lkm_pkg::TAG_DATA) begin
                        o_state.recv_run = 1'b1;
                        o_state.recv_cnt = lkm_pkg::CNT_ONE;
                        o_res.act0       = lkm_pkg::ACT_DLV_RX;
                    end
                end
            end
            lkm_pkg::KIND_TX: begin
                if (i_state.phase == lkm_pkg::PH_LINKED) begin
                    o_res.act0 = lkm_pkg::ACT_FWD_TX;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> rtl/core/link_keepalive_manager.sv
// ----------------------------------------------------------------------------
// link_keepalive_manager
// Reflector link manager: link phase, poll send timer and receive timeout.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tuser: kind; tdata: elapsed, open ok, peer, tag
//  m_axis    | out       | tdata: action, link state, lost link; tlast
//  cfg write | in        | register index and data, written on enable
//
//  one event enters the input register per cycle unless m_axis stalls; it is
//  then resolved from the input register into the result register.
//  a poll reply while linking gives two results and holds back the next event
//  until the second result leaves; every other event gives one result per cycle.
//  a stall on m_axis backs up through the result and input registers.
//  synchronous active-low reset: phase not open, both timers stopped.
// ----------------------------------------------------------------------------
module link_keepalive_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_wdata,
    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // elapsed_ms, open_succeeded, from_peer, packet_tag
    input  logic [3:0]  s_axis_tuser,   // kind
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // action, link_state, lost_link
    output logic        m_axis_tlast
);

    typedef struct packed {
        lkm_pkg::t_action action;
        lkm_pkg::t_phase  phase;
        logic             lost;
        logic             last;
    } t_result;

    lkm_pkg::t_cfg        r_cfg;
    lkm_pkg::t_link_state r_st, n_st, step_st;
    lkm_pkg::t_item       r_in, n_in;
    lkm_pkg::t_step_res   step_res;
    logic                 r_in_vld, n_in_vld;
    logic                 r_o_vld, n_o_vld;
    logic                 r_o2_vld, n_o2_vld;
    t_result              r_o, n_o, r_o2, n_o2;
    logic                 s_fire, m_fire, out_free, proc;

    // handshake and progress conditions
    assign m_fire        = r_o_vld && m_axis_tready;
    assign out_free      = !r_o_vld || (m_axis_tready && !r_o2_vld);
    assign proc          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || proc;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // event resolution
    lkm_step u_step (
        .i_state (r_st),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_state (step_st),
        .o_res   (step_res)
    );

    // next values of input, result and state registers
    always_comb begin
        n_in_vld = r_in_vld;
        n_in     = r_in;
        n_o_vld  = r_o_vld;
        n_o      = r_o;
        n_o2_vld = r_o2_vld;
        n_o2     = r_o2;
        n_st     = r_st;
        if (s_fire) begin
            n_in_vld          = 1'b1;
            n_in.kind         = s_axis_tuser;
            n_in.elapsed_ms   = s_axis_tdata[15:0];
            n_in.open_ok      = s_axis_tdata[16];
            n_in.from_peer    = s_axis_tdata[17];
            n_in.tag          = s_axis_tdata[49:18];
        end else if (proc) begin
            n_in_vld = 1'b0;
        end
        if (m_fire) begin
            if (r_o2_vld) begin
                n_o      = r_o2;
                n_o2_vld = 1'b0;
            end else begin
                n_o_vld = 1'b0;
            end
        end
        if (proc) begin
            n_st     = step_st;
            n_o_vld  = 1'b1;
            n_o      = '{action: step_res.act0, phase: step_st.phase,
                         lost: step_res.lost, last: !step_res.two};
            n_o2_vld = step_res.two;
            n_o2     = '{action: step_res.act1, phase: step_st.phase,
                         lost: step_res.lost, last: 1'b1};
        end
    end

    // control state, link state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld          <= 1'b0;
            r_o_vld           <= 1'b0;
            r_o2_vld          <= 1'b0;
            r_st.phase        <= lkm_pkg::PH_NOTOPEN;
            r_st.send_run     <= 1'b0;
            r_st.send_cnt     <= '0;
            r_st.recv_run     <= 1'b0;
            r_st.recv_cnt     <= '0;
            r_cfg.static_mode <= 1'b0;
            r_cfg.peer_valid  <= 1'b1;
            r_cfg.poll_period <= lkm_pkg::POLL_RST;
            r_cfg.link_tmo    <= lkm_pkg::TMO_RST;
        end else begin
            r_in_vld <= n_in_vld;
            r_o_vld  <= n_o_vld;
            r_o2_vld <= n_o2_vld;
            r_st     <= n_st;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    lkm_pkg::REG_STATIC_MODE: r_cfg.static_mode <= i_cfg_wdata[0];
                    lkm_pkg::REG_PEER_VALID:  r_cfg.peer_valid  <= i_cfg_wdata[0];
                    lkm_pkg::REG_POLL_PERIOD: r_cfg.poll_period <= i_cfg_wdata[15:0];
                    lkm_pkg::REG_LINK_TMO:    r_cfg.link_tmo    <= i_cfg_wdata;
                    default:                  r_cfg             <= r_cfg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_o  <= n_o;
        r_o2 <= n_o2;
    end

    // output mapping
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {2'b00, r_o.lost, r_o.phase, r_o.action};
    assign m_axis_tlast  = r_o.last;

    // a pending second result sits behind a valid, non-final first result
    a_second_behind_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o2_vld |-> (m_axis_tvalid && !m_axis_tlast))
        else $error("second result pending without a non-final first result");

    // a stopped timer always holds a zero count
    a_timers_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_st.send_run |-> (r_st.send_cnt == '0)) and
        (!r_st.recv_run |-> (r_st.recv_cnt == '0)))
        else $error("stopped timer holds a non-zero count");

    // reset leaves the link not open with no results in flight
    a_reset_state : assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_st.phase == lkm_pkg::PH_NOTOPEN) && !m_axis_tvalid && !r_o2_vld))
        else $error("link not cleared by reset");

endmodule

>>> dv/link_keepalive_checker.sv
// ----------------------------------------------------------------------------
// link_keepalive_checker
// Watches the event, result and configuration channels of the link keepalive
// manager, predicts every result from its own copy of the link phase, timers
// and settings, and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module link_keepalive_checker
    import lkm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // elapsed_ms, open_succeeded, from_peer, packet_tag
    input  logic [3:0]  s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // action, link_state, lost_link
    input  logic        m_axis_tlast,
    output int          o_failures,
    output int          o_outstanding,
    output int          o_results_seen,
    output int          o_lost_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        t_action act;
        t_phase  phase;
        logic    lost;
        logic    last;
    } due_result_t;

    // results predicted but not yet seen, oldest first
    due_result_t due_results[$];

    // shadow settings
    logic                  cfg_static;
    logic                  cfg_peer_ok;
    logic [POLL_W-1:0]     cfg_poll;
    logic [TIMEOUT_W-1:0]  cfg_tmo;

    // shadow link state
    t_phase                link_phase;
    logic                  send_run;
    logic [TIMER_BITS-1:0] send_cnt;
    logic                  recv_run;
    logic [TIMER_BITS-1:0] recv_cnt;

    t_item seen_ev;
    int    failures     = 0;
    int    results_seen = 0;
    int    lost_seen    = 0;

    initial begin
        o_failures     = 0;
        o_outstanding  = 0;
        o_results_seen = 0;
        o_lost_seen    = 0;
    end

    task automatic flag_mismatch(input string msg);
        failures++;
        // keep the log readable on a badly broken build
        if (failures <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // saturating millisecond count
    function automatic logic [TIMER_BITS-1:0] timer_add(
        input logic [TIMER_BITS-1:0] cnt,
        input logic [MS_W-1:0]       ms
    );
        logic [TIMER_BITS:0] sum;
        sum = {1'b0, cnt} + (TIMER_BITS+1)'(ms);
        return sum[TIMER_BITS] ? CNT_MAX : sum[TIMER_BITS-1:0];
    endfunction

    // work out the results of one event and queue them
    task automatic resolve_event(input t_item ev);
        t_action acts[2];
        int      n;
        logic    lost;
        n    = 0;
        lost = 1'b0;
        case (ev.kind)
            KIND_OPEN: begin
                link_phase = (cfg_peer_ok && ev.open_ok) ? PH_NOTLINKED : PH_NOTOPEN;
            end
            KIND_LINK: begin
                if (link_phase == PH_NOTLINKED) begin
                    link_phase = PH_LINKING;
                    send_run   = 1'b1;
                    send_cnt   = CNT_ONE;
                    recv_run   = 1'b1;
                    recv_cnt   = CNT_ONE;
                    acts[n]    = ACT_POLL;
                    n++;
                end
            end
            KIND_UNLINK: begin
                if (link_phase == PH_LINKED) begin
                    send_run   = 1'b0;
                    send_cnt   = '0;
                    recv_run   = 1'b0;
                    recv_cnt   = '0;
                    acts[n]    = ACT_UNLINK;
                    n++;
                    link_phase = PH_NOTLINKED;
                end
            end
            KIND_CLOSE: begin
                link_phase = PH_NOTOPEN;
            end
            KIND_TICK: begin
                if (link_phase != PH_NOTOPEN) begin
                    // receive timeout first, it decides the phase for the poll
                    if (recv_run && cfg_tmo != '0) begin
                        recv_cnt = timer_add(recv_cnt, ev.elapsed_ms);
                    end
                    if (recv_run && cfg_tmo != '0 && recv_cnt >= cfg_tmo) begin
                        if (cfg_static) begin
                            link_phase = PH_LINKING;
                        end else begin
                            link_phase = PH_NOTLINKED;
                            send_run   = 1'b0;
                            send_cnt   = '0;
                        end
                        lost     = 1'b1;
                        recv_run = 1'b0;
                        recv_cnt = '0;
                    end
                    // keepalive poll, timer restarts whatever the phase
                    if (send_run && cfg_poll != '0) begin
                        send_cnt = timer_add(send_cnt, ev.elapsed_ms);
                    end
                    if (send_run && cfg_poll != '0 && send_cnt >= TIMER_BITS'(cfg_poll)) begin
                        if (link_phase == PH_LINKING || link_phase == PH_LINKED) begin
                            acts[n] = ACT_POLL;
                            n++;
                        end
                        send_run = 1'b1;
                        send_cnt = CNT_ONE;
                    end
                end
            end
            KIND_RX: begin
                if (link_phase != PH_NOTOPEN && cfg_peer_ok && ev.from_peer) begin
                    if (ev.tag == TAG_POLL) begin
                        recv_run = 1'b1;
                        recv_cnt = CNT_ONE;
                        if (link_phase == PH_LINKING) begin
                            link_phase = PH_LINKED;
                            acts[n]    = ACT_OPTIONS;
                            n++;
                            acts[n]    = ACT_INFO;
                            n++;
                        end
                    end else if (ev.tag == TAG_DATA) begin
                        recv_run = 1'b1;
                        recv_cnt = CNT_ONE;
                        acts[n]  = ACT_DLV_RX;
                        n++;
                    end
                end
            end
            KIND_TX: begin
                if (link_phase == PH_LINKED) begin
                    acts[n] = ACT_FWD_TX;
                    n++;
                end
            end
            default: begin
            end
        endcase
        if (n == 0) begin
            acts[0] = ACT_NONE;
            n       = 1;
        end
        for (int k = 0; k < n; k++) begin
            due_results.push_back('{act: acts[k], phase: link_phase, lost: lost,
                                    last: (k == n - 1)});
        end
    endtask

    // compare one result transfer against the oldest prediction
    task automatic check_result();
        due_result_t want;
        t_action     got_act;
        t_phase      got_phase;
        logic        got_lost;
        got_act   = t_action'(m_axis_tdata[2:0]);
        got_phase = t_phase'(m_axis_tdata[4:3]);
        got_lost  = m_axis_tdata[5];
        results_seen++;
        if (due_results.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending: action %0d state %0d",
                                    got_act, got_phase));
            return;
        end
        want = due_results.pop_front();
        if (want.lost && want.last) begin
            lost_seen++;
        end
        if (got_act !== want.act) begin
            flag_mismatch($sformatf("action %0d, predicted %0d", got_act, want.act));
        end
        if (got_phase !== want.phase) begin
            flag_mismatch($sformatf("link state %0d, predicted %0d", got_phase, want.phase));
        end
        if (got_lost !== want.lost) begin
            flag_mismatch($sformatf("lost link %b, predicted %b", got_lost, want.lost));
        end
        if (m_axis_tlast !== want.last) begin
            flag_mismatch($sformatf("tlast %b, predicted %b", m_axis_tlast, want.last));
        end
    endtask

    // sample all channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_static  = 1'b0;
            cfg_peer_ok = 1'b1;
            cfg_poll    = POLL_RST;
            cfg_tmo     = TMO_RST;
            link_phase  = PH_NOTOPEN;
            send_run    = 1'b0;
            send_cnt    = '0;
            recv_run    = 1'b0;
            recv_cnt    = '0;
            due_results.delete();
        end else begin
            // results are always older than an event arriving on the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_STATIC_MODE: cfg_static  = i_cfg_wdata[0];
                    REG_PEER_VALID:  cfg_peer_ok = i_cfg_wdata[0];
                    REG_POLL_PERIOD: cfg_poll    = i_cfg_wdata[POLL_W-1:0];
                    REG_LINK_TMO:    cfg_tmo     = i_cfg_wdata[TIMEOUT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_ev.kind       = s_axis_tuser;
                seen_ev.elapsed_ms = s_axis_tdata[15:0];
                seen_ev.open_ok    = s_axis_tdata[16];
                seen_ev.from_peer  = s_axis_tdata[17];
                seen_ev.tag        = s_axis_tdata[49:18];
                resolve_event(seen_ev);
            end
        end
        o_outstanding  <= due_results.size();
        o_failures     <= failures;
        o_results_seen <= results_seen;
        o_lost_seen    <= lost_seen;
    end

endmodule

>>> dv/link_keepalive_manager_test.sv
// ----------------------------------------------------------------------------
// link_keepalive_manager_test
// Drives open, link, unlink, close, tick, receive and transmit events into the
// link keepalive manager under several timer and mode settings, with bursty
// input and a stalling result sink; the checker beside the block does the
// prediction and comparison, this module reports the verdict.
// ----------------------------------------------------------------------------
module link_keepalive_manager_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lkm_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 185;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500_000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [17:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // elapsed_ms, open_succeeded, from_peer, packet_tag
    logic [3:0]  s_axis_tuser  = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // action, link_state, lost_link
    logic        m_axis_tlast;

    int failures;
    int outstanding;
    int results_seen;
    int lost_seen;

    int cycle_count   = 0;
    int events_sent   = 0;
    int settings_used = 0;
    int burst_left    = 0;

    link_keepalive_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    link_keepalive_checker link_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .o_failures     (failures),
        .o_outstanding  (outstanding),
        .o_results_seen (results_seen),
        .o_lost_seen    (lost_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // result sink: segments of free flow, random back-pressure and long stalls
    initial begin
        int   mode;
        int   seg_left;
        int   stall_left;
        logic ready;
        mode       = 0;
        seg_left   = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                0: ready = 1'b1;
                1: ready = ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        ready = 1'b0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        ready      = 1'b0;
                    end else begin
                        ready = 1'b1;
                    end
                end
            endcase
            m_axis_tready <= ready;
        end
    end

    function automatic t_item event_of(
        input logic [KIND_W-1:0] kind,
        input logic [MS_W-1:0]   ms,
        input logic              ok,
        input logic              peer,
        input logic [TAG_W-1:0]  tag
    );
        t_item ev;
        ev.kind       = kind;
        ev.elapsed_ms = ms;
        ev.open_ok    = ok;
        ev.from_peer  = peer;
        ev.tag        = tag;
        return ev;
    endfunction

    // random event weighted towards the live link; unused fields stay random
    function automatic t_item session_event(input int span);
        t_item ev;
        int    roll;
        int    pick;
        ev   = event_of(KIND_W'($urandom_range(0, 15)), MS_W'($urandom), 1'($urandom),
                        1'($urandom), $urandom);
        roll = $urandom_range(0, 99);
        if (roll < 38) begin
            ev.kind = KIND_TICK;
            pick    = $urandom_range(0, 19);
            if (pick == 0) begin
                ev.elapsed_ms = '0;
            end else if (pick == 1) begin
                ev.elapsed_ms = '1;
            end else if (pick > 3) begin
                ev.elapsed_ms = MS_W'($urandom_range(0, span));
            end
        end else if (roll < 58) begin
            ev.kind      = KIND_RX;
            ev.from_peer = ($urandom_range(0, 9) != 0);
            pick         = $urandom_range(0, 9);
            if (pick < 6) begin
                ev.tag = TAG_POLL;
            end else if (pick < 8) begin
                ev.tag = TAG_DATA;
            end else if (pick == 8) begin
                // one bit away from a poll tag
                ev.tag = TAG_POLL ^ (32'd1 << $urandom_range(0, 31));
            end
        end else if (roll < 72) begin
            ev.kind = KIND_TX;
        end else if (roll < 78) begin
            ev.kind = KIND_LINK;
        end else if (roll < 82) begin
            ev.kind = KIND_UNLINK;
        end else if (roll < 85) begin
            ev.kind = KIND_CLOSE;
        end else if (roll < 89) begin
            ev.kind    = KIND_OPEN;
            ev.open_ok = ($urandom_range(0, 5) != 0);
        end else begin
            ev.kind = KIND_W'($urandom_range(7, 15));
        end
        return ev;
    endfunction

    // one event transfer, with bursts and random gaps in between
    task automatic push_event(input t_item ev);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ev.tag, ev.from_peer, ev.open_ok, ev.elapsed_ms};
        s_axis_tuser  <= ev.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        events_sent++;
    endtask

    // hold the input until every predicted result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic program_link(
        input logic     st,
        input logic     peer_ok,
        input int       poll_ms,
        input int       tmo_ms
    );
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= REG_STATIC_MODE;
        i_cfg_wdata <= CFG_DAT_W'(st);
        @(posedge i_clk);
        i_cfg_addr  <= REG_PEER_VALID;
        i_cfg_wdata <= CFG_DAT_W'(peer_ok);
        @(posedge i_clk);
        i_cfg_addr  <= REG_POLL_PERIOD;
        i_cfg_wdata <= CFG_DAT_W'(poll_ms);
        @(posedge i_clk);
        i_cfg_addr  <= REG_LINK_TMO;
        i_cfg_wdata <= CFG_DAT_W'(tmo_ms);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // stimulus
    initial begin
        logic st;
        logic peer_ok;
        int   poll_ms;
        int   tmo_ms;
        int   span;
        int   sent;
        int   len;
        bit   paused;
        paused = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, walk every phase and the ignored cases
        push_event(event_of(KIND_TICK, 16'd100, 1'b1, 1'b1, TAG_POLL));
        push_event(event_of(KIND_RX, 16'd0, 1'b1, 1'b1, TAG_POLL));
        push_event(event_of(KIND_LINK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_OPEN, 16'd0, 1'b0, 1'b1, '0));
        push_event(event_of(KIND_OPEN, 16'd0, 1'b1, 1'b0, '1));
        push_event(event_of(KIND_UNLINK, 16'hFFFF, 1'b1, 1'b1, '1));
        push_event(event_of(KIND_TX, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_LINK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b0, TAG_POLL));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_DATA));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_POLL));
        push_event(event_of(KIND_TX, 16'hFFFF, 1'b1, 1'b1, '1));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_POLL));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, 32'hFFFF_FFFF));
        push_event(event_of(KIND_TICK, 16'd5000, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_TICK, 16'hFFFF, 1'b0, 1'b0, '0));
        push_event(event_of(4'hF, 16'hFFFF, 1'b1, 1'b1, '1));
        push_event(event_of(KIND_LINK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_POLL));
        push_event(event_of(KIND_UNLINK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_CLOSE, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_TICK, 16'd0, 1'b0, 1'b0, '0));

        // static mode with shortest periods: timeout and poll in the same tick
        wait_drained();
        program_link(1'b1, 1'b1, 1, 1);
        push_event(event_of(KIND_OPEN, 16'd0, 1'b1, 1'b0, '0));
        push_event(event_of(KIND_LINK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_TICK, 16'd0, 1'b0, 1'b0, '0));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_POLL));

        // peer address unresolved: open fails, packets ignored
        wait_drained();
        program_link(1'b0, 1'b0, int'(POLL_RST), int'(TMO_RST));
        push_event(event_of(KIND_OPEN, 16'd0, 1'b1, 1'b1, '0));
        push_event(event_of(KIND_RX, 16'd0, 1'b0, 1'b1, TAG_POLL));

        // random sessions under a series of settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin st = 1'b0; peer_ok = 1'b1; poll_ms = 1;     tmo_ms = 262143; end
                1: begin st = 1'b1; peer_ok = 1'b1; poll_ms = 65535; tmo_ms = 1;      end
                2: begin
                    st = 1'b1; peer_ok = 1'b1;
                    poll_ms = $urandom_range(20, 300); tmo_ms = $urandom_range(200, 2000);
                end
                3: begin
                    st = 1'b0; peer_ok = 1'b1;
                    poll_ms = $urandom_range(20, 300); tmo_ms = $urandom_range(200, 2000);
                end
                4: begin
                    st = 1'b0; peer_ok = 1'b0;
                    poll_ms = int'(POLL_RST); tmo_ms = int'(TMO_RST);
                end
                default: begin
                    st      = 1'($urandom_range(0, 1));
                    peer_ok = ($urandom_range(0, 5) != 0);
                    poll_ms = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 500)
                                                          : $urandom_range(1, 65535);
                    tmo_ms  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3000)
                                                          : $urandom_range(1, 262143);
                end
            endcase
            // tick sizes scaled so both timers get a chance to fire
            span = ((poll_ms < tmo_ms) ? poll_ms : tmo_ms) / 2;
            if (span < 2) span = 2;
            if (span > 65535) span = 65535;

            wait_drained();
            program_link(st, peer_ok, poll_ms, tmo_ms);
            sent = 0;
            while (sent < PHASE_EVENTS) begin
                // well-formed opening, then random traffic on the link
                push_event(event_of(KIND_OPEN, MS_W'($urandom), 1'b1, 1'($urandom), $urandom));
                push_event(event_of(KIND_LINK, MS_W'($urandom), 1'($urandom), 1'($urandom),
                                    $urandom));
                push_event(event_of(KIND_RX, MS_W'($urandom), 1'($urandom), 1'b1, TAG_POLL));
                len = $urandom_range(8, 60);
                repeat (len) push_event(session_event(span));
                sent += len + 3;
                if (ph == 3 && !paused && sent > PHASE_EVENTS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d events under %0d link settings, %0d results checked",
                 events_sent, settings_used, results_seen);
        $display("link timeouts seen: %0d, cycles run: %0d", lost_seen, cycle_count);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lkm_pkg.sv
rtl/core/lkm_step.sv
rtl/core/link_keepalive_manager.sv
dv/link_keepalive_checker.sv
dv/link_keepalive_manager_test.sv
